// ===== rtl/core/afw_pkg.sv =====
// ----------------------------------------------------------------------------
// afw_pkg
// Shared sizes, register indexes and inter-stage structs of the affine warp
// texel sampler. Source sizes are powers of two (coordinate wrap is a mask).
// ----------------------------------------------------------------------------
package afw_pkg;

    localparam int SRC_WIDTH  = 64;
    localparam int SRC_HEIGHT = 32;
    localparam int FRAC_BITS  = 8;

    localparam int COL_W  = 6;
    localparam int ROW_W  = 5;
    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int CFG_W  = 20;
    localparam int MODE_W = 2;

    localparam int XW         = $clog2(SRC_WIDTH);
    localparam int YW         = $clog2(SRC_HEIGHT);
    localparam int S_W        = CFG_W + COL_W + 2;
    localparam int BANK_AW    = XW + YW - 2;
    localparam int BANK_DEPTH = SRC_WIDTH * SRC_HEIGHT / 4;
    localparam int WT_W       = FRAC_BITS + 1;
    localparam int HB_W       = CH_W + FRAC_BITS;
    localparam int VB_W       = CH_W + 2 * FRAC_BITS;

    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int APB_DW    = 32;

    localparam logic [WT_W-1:0] ONE_FX = WT_W'(1 << FRAC_BITS);

    localparam logic [REG_IDX_W-1:0] REG_SCALE_MODE    = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_EMPTY_OUTSIDE = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_M_XX          = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_M_XY          = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_M_TX          = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_M_YX          = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_M_YY          = REG_IDX_W'(6);
    localparam logic [REG_IDX_W-1:0] REG_M_TY          = REG_IDX_W'(7);

    localparam logic [MODE_W-1:0] SCALE_NEAREST  = MODE_W'(0);
    localparam logic [MODE_W-1:0] SCALE_BILINEAR = MODE_W'(1);
    localparam logic              MODE_WRITE     = 1'b0;
    localparam logic              MODE_RENDER    = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0] scale_mode;
        logic              empty_outside;
        logic [CFG_W-1:0]  m_xx;
        logic [CFG_W-1:0]  m_xy;
        logic [CFG_W-1:0]  m_tx;
        logic [CFG_W-1:0]  m_yx;
        logic [CFG_W-1:0]  m_yy;
        logic [CFG_W-1:0]  m_ty;
    } t_cfg;

    // placed sample position, or a texel write, heading for the store
    typedef struct packed {
        logic                 vld;
        logic                 ren;
        logic                 outside;
        logic [XW-1:0]        ix;
        logic [FRAC_BITS-1:0] fx;
        logic [YW-1:0]        iy;
        logic [FRAC_BITS-1:0] fy;
        logic [XW-1:0]        wcol;
        logic [YW-1:0]        wrow;
        logic [PIX_W-1:0]     wdata;
    } t_smp;

    // bank read data plus what the blend needs to pick the corners
    typedef struct packed {
        logic                  vld;
        logic                  outside;
        logic                  near;
        logic                  x0b;
        logic                  x1b;
        logic                  y0b;
        logic                  y1b;
        logic                  sel_x;
        logic                  sel_y;
        logic [FRAC_BITS-1:0]  fx;
        logic [FRAC_BITS-1:0]  fy;
        logic [3:0][PIX_W-1:0] q;
    } t_tex;

endpackage

// ===== rtl/core/afw_xform.sv =====
// ----------------------------------------------------------------------------
// afw_xform
// Affine map of the display pixel to a source position (products, sum) and
// placement of each coordinate into the image: wrap or outside test.
// ----------------------------------------------------------------------------
module afw_xform (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  afw_pkg::t_cfg                i_cfg,
    input  logic                         i_go,
    input  logic                         i_mode,
    input  logic [afw_pkg::COL_W-1:0]    i_col,
    input  logic [afw_pkg::ROW_W-1:0]    i_row,
    input  logic [afw_pkg::PIX_W-1:0]    i_wdata,
    output afw_pkg::t_smp                o_smp
);

    localparam int S_W   = afw_pkg::S_W;
    localparam int CFG_W = afw_pkg::CFG_W;
    localparam int COL_W = afw_pkg::COL_W;
    localparam int ROW_W = afw_pkg::ROW_W;
    localparam int XW    = afw_pkg::XW;
    localparam int YW    = afw_pkg::YW;
    localparam int FB    = afw_pkg::FRAC_BITS;

    logic signed [CFG_W+COL_W:0] n_pxc, n_pyc;
    logic signed [CFG_W+ROW_W:0] n_pxr, n_pyr;

    logic                        r1_vld, r1_ren;
    logic [XW-1:0]               r1_wcol;
    logic [YW-1:0]               r1_wrow;
    logic [afw_pkg::PIX_W-1:0]   r1_wdata;
    logic signed [S_W-1:0]       r1_pxc, r1_pxr, r1_pyc, r1_pyr;

    logic                        r2_vld, r2_ren;
    logic [XW-1:0]               r2_wcol;
    logic [YW-1:0]               r2_wrow;
    logic [afw_pkg::PIX_W-1:0]   r2_wdata;
    logic signed [S_W-1:0]       r2_sx, r2_sy;

    logic [S_W-1:0]              n_mag_x, n_mag_y;
    logic [XW+FB-1:0]            n_ax;
    logic [YW+FB-1:0]            n_ay;
    logic                        n_out_x, n_out_y;

    afw_pkg::t_smp               r3_smp;

    assign n_pxc = $signed(i_cfg.m_xx) * $signed({1'b0, i_col});
    assign n_pxr = $signed(i_cfg.m_xy) * $signed({1'b0, i_row});
    assign n_pyc = $signed(i_cfg.m_yx) * $signed({1'b0, i_col});
    assign n_pyr = $signed(i_cfg.m_yy) * $signed({1'b0, i_row});

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_go;
        end
        r1_ren   <= (i_mode == afw_pkg::MODE_RENDER);
        r1_wcol  <= XW'(i_col);
        r1_wrow  <= YW'(i_row);
        r1_wdata <= i_wdata;
        r1_pxc   <= S_W'(n_pxc);
        r1_pxr   <= S_W'(n_pxr);
        r1_pyc   <= S_W'(n_pyc);
        r1_pyr   <= S_W'(n_pyr);
    end

    // stage 2: sums with offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_ren   <= r1_ren;
        r2_wcol  <= r1_wcol;
        r2_wrow  <= r1_wrow;
        r2_wdata <= r1_wdata;
        r2_sx    <= r1_pxc + r1_pxr + S_W'($signed(i_cfg.m_tx));
        r2_sy    <= r1_pyc + r1_pyr + S_W'($signed(i_cfg.m_ty));
    end

    // stage 3: placement; loop mode keeps |s| mod period, a mask here
    always_comb begin
        n_mag_x = r2_sx[S_W-1] ? S_W'(-r2_sx) : S_W'(r2_sx);
        n_mag_y = r2_sy[S_W-1] ? S_W'(-r2_sy) : S_W'(r2_sy);
        n_ax    = i_cfg.empty_outside ? r2_sx[XW+FB-1:0] : n_mag_x[XW+FB-1:0];
        n_ay    = i_cfg.empty_outside ? r2_sy[YW+FB-1:0] : n_mag_y[YW+FB-1:0];
        n_out_x = r2_sx[S_W-1] | (|r2_sx[S_W-2:XW+FB]);
        n_out_y = r2_sy[S_W-1] | (|r2_sy[S_W-2:YW+FB]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_smp.vld <= 1'b0;
        end else begin
            r3_smp.vld <= r2_vld;
        end
        r3_smp.ren     <= r2_ren;
        r3_smp.outside <= i_cfg.empty_outside & (n_out_x | n_out_y);
        r3_smp.ix      <= n_ax[XW+FB-1:FB];
        r3_smp.fx      <= n_ax[FB-1:0];
        r3_smp.iy      <= n_ay[YW+FB-1:FB];
        r3_smp.fy      <= n_ay[FB-1:0];
        r3_smp.wcol    <= r2_wcol;
        r3_smp.wrow    <= r2_wrow;
        r3_smp.wdata   <= r2_wdata;
    end

    assign o_smp = r3_smp;

endmodule

// ===== rtl/core/afw_tex_store.sv =====
// ----------------------------------------------------------------------------
// afw_tex_store
// Source image in four banks split by column and row parity, so the four
// bilinear neighbours are read in the same cycle. Writes use the same stage.
// ----------------------------------------------------------------------------
module afw_tex_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  afw_pkg::t_cfg             i_cfg,
    input  afw_pkg::t_smp             i_smp,
    output afw_pkg::t_tex             o_tex
);

    localparam int XW = afw_pkg::XW;
    localparam int YW = afw_pkg::YW;
    localparam int AW = afw_pkg::BANK_AW;
    localparam int FB = afw_pkg::FRAC_BITS;

    logic [XW-1:0]  n_x1;
    logic [YW-1:0]  n_y1;
    logic [XW-1:0]  n_bx [2];
    logic [YW-1:0]  n_by [2];
    logic [AW-1:0]  n_raddr [4];
    logic [AW-1:0]  n_waddr;
    logic [1:0]     n_wbank;
    logic [3:0]     n_wr_en;

    logic           r_vld, r_outside, r_near;
    logic           r_x0b, r_x1b, r_y0b, r_y1b, r_sel_x, r_sel_y;
    logic [FB-1:0]  r_fx, r_fy;

    // next neighbour: wraps to 0 in loop mode, clamps in empty mode
    always_comb begin
        if (i_smp.ix == XW'(afw_pkg::SRC_WIDTH - 1)) begin
            n_x1 = i_cfg.empty_outside ? i_smp.ix : '0;
        end else begin
            n_x1 = XW'(i_smp.ix + 1'b1);
        end
        if (i_smp.iy == YW'(afw_pkg::SRC_HEIGHT - 1)) begin
            n_y1 = i_cfg.empty_outside ? i_smp.iy : '0;
        end else begin
            n_y1 = YW'(i_smp.iy + 1'b1);
        end
        // a clamped neighbour shares its bank with the base texel
        n_bx[0] = i_smp.ix[0] ? n_x1 : i_smp.ix;
        n_bx[1] = i_smp.ix[0] ? i_smp.ix : n_x1;
        n_by[0] = i_smp.iy[0] ? n_y1 : i_smp.iy;
        n_by[1] = i_smp.iy[0] ? i_smp.iy : n_y1;
        n_raddr[0] = {n_by[0][YW-1:1], n_bx[0][XW-1:1]};
        n_raddr[1] = {n_by[0][YW-1:1], n_bx[1][XW-1:1]};
        n_raddr[2] = {n_by[1][YW-1:1], n_bx[0][XW-1:1]};
        n_raddr[3] = {n_by[1][YW-1:1], n_bx[1][XW-1:1]};
        n_waddr    = {i_smp.wrow[YW-1:1], i_smp.wcol[XW-1:1]};
        n_wbank    = {i_smp.wrow[0], i_smp.wcol[0]};
        for (int b = 0; b < 4; b++) begin
            n_wr_en[b] = i_smp.vld & ~i_smp.ren & (n_wbank == 2'(b));
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [afw_pkg::PIX_W-1:0] r_mem [afw_pkg::BANK_DEPTH];
        logic [afw_pkg::PIX_W-1:0] r_q;

        always_ff @(posedge i_clk) begin
            if (n_wr_en[b]) begin
                r_mem[n_waddr] <= i_smp.wdata;
            end
            r_q <= r_mem[n_raddr[b]];
        end

        assign o_tex.q[b] = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_smp.vld & i_smp.ren;
        end
        r_outside <= i_smp.outside;
        r_near    <= (i_cfg.scale_mode == afw_pkg::SCALE_NEAREST);
        r_x0b     <= i_smp.ix[0];
        r_x1b     <= n_x1[0];
        r_y0b     <= i_smp.iy[0];
        r_y1b     <= n_y1[0];
        r_sel_x   <= i_smp.fx[FB-1];
        r_sel_y   <= i_smp.fy[FB-1];
        r_fx      <= i_smp.fx;
        r_fy      <= i_smp.fy;
    end

    assign o_tex.vld     = r_vld;
    assign o_tex.outside = r_outside;
    assign o_tex.near    = r_near;
    assign o_tex.x0b     = r_x0b;
    assign o_tex.x1b     = r_x1b;
    assign o_tex.y0b     = r_y0b;
    assign o_tex.y1b     = r_y1b;
    assign o_tex.sel_x   = r_sel_x;
    assign o_tex.sel_y   = r_sel_y;
    assign o_tex.fx      = r_fx;
    assign o_tex.fy      = r_fy;

endmodule

// ===== rtl/core/afw_blend.sv =====
// ----------------------------------------------------------------------------
// afw_blend
// Corner selection, horizontal blend of top and bottom rows, vertical blend,
// nearest pick, zeroing of outside samples and the registered result word.
// ----------------------------------------------------------------------------
module afw_blend (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  afw_pkg::t_tex               i_tex,
    output logic                        o_valid,
    output logic [afw_pkg::CH_W-1:0]    o_red,
    output logic [afw_pkg::CH_W-1:0]    o_green,
    output logic [afw_pkg::CH_W-1:0]    o_blue,
    output logic                        o_outside
);

    localparam int CH_W = afw_pkg::CH_W;
    localparam int HB_W = afw_pkg::HB_W;
    localparam int VB_W = afw_pkg::VB_W;
    localparam int WT_W = afw_pkg::WT_W;
    localparam int FB   = afw_pkg::FRAC_BITS;

    logic [afw_pkg::PIX_W-1:0] n_tl, n_tr, n_bl, n_br, n_near;
    logic [WT_W-1:0]           n_wx0, n_wx1, n_wy0, n_wy1;
    logic [HB_W:0]             n_top [3];
    logic [HB_W:0]             n_bot [3];
    logic [VB_W:0]             n_v [3];

    logic                      r5_vld, r5_outside, r5_near;
    logic [afw_pkg::PIX_W-1:0] r5_texel;
    logic [FB-1:0]             r5_fy;
    logic [HB_W-1:0]           r5_top [3];
    logic [HB_W-1:0]           r5_bot [3];

    logic                      r_valid, r_outside;
    logic [CH_W-1:0]           r_ch [3];

    always_comb begin
        n_tl   = i_tex.q[{i_tex.y0b, i_tex.x0b}];
        n_tr   = i_tex.q[{i_tex.y0b, i_tex.x1b}];
        n_bl   = i_tex.q[{i_tex.y1b, i_tex.x0b}];
        n_br   = i_tex.q[{i_tex.y1b, i_tex.x1b}];
        n_near = i_tex.q[{i_tex.sel_y ? i_tex.y1b : i_tex.y0b,
                          i_tex.sel_x ? i_tex.x1b : i_tex.x0b}];
        n_wx1  = WT_W'(i_tex.fx);
        n_wx0  = afw_pkg::ONE_FX - n_wx1;
        for (int c = 0; c < 3; c++) begin
            n_top[c] = (HB_W+1)'(n_tl[c*CH_W +: CH_W]) * (HB_W+1)'(n_wx0)
                     + (HB_W+1)'(n_tr[c*CH_W +: CH_W]) * (HB_W+1)'(n_wx1);
            n_bot[c] = (HB_W+1)'(n_bl[c*CH_W +: CH_W]) * (HB_W+1)'(n_wx0)
                     + (HB_W+1)'(n_br[c*CH_W +: CH_W]) * (HB_W+1)'(n_wx1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= i_tex.vld;
        end
        r5_outside <= i_tex.outside;
        r5_near    <= i_tex.near;
        r5_texel   <= n_near;
        r5_fy      <= i_tex.fy;
        for (int c = 0; c < 3; c++) begin
            r5_top[c] <= n_top[c][HB_W-1:0];
            r5_bot[c] <= n_bot[c][HB_W-1:0];
        end
    end

    always_comb begin
        n_wy1 = WT_W'(r5_fy);
        n_wy0 = afw_pkg::ONE_FX - n_wy1;
        for (int c = 0; c < 3; c++) begin
            n_v[c] = (VB_W+1)'(r5_top[c]) * (VB_W+1)'(n_wy0)
                   + (VB_W+1)'(r5_bot[c]) * (VB_W+1)'(n_wy1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r5_vld;
        end
        r_outside <= r5_outside;
        for (int c = 0; c < 3; c++) begin
            if (r5_outside) begin
                r_ch[c] <= '0;
            end else if (r5_near) begin
                r_ch[c] <= r5_texel[c*CH_W +: CH_W];
            end else begin
                r_ch[c] <= n_v[c][VB_W-1:2*FB];
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_outside = r_outside;
    assign o_red     = r_ch[2];
    assign o_green   = r_ch[1];
    assign o_blue    = r_ch[0];

endmodule

// ===== rtl/core/affine_warp_texel_sampler_core.sv =====
// ----------------------------------------------------------------------------
// affine_warp_texel_sampler_core
// Affine warp sampler over a stored RGB texture: nearest or bilinear, with
// wrap or empty edge handling; register file on an APB-style port.
// ----------------------------------------------------------------------------
//  channel   handshake                          payload
//  input     start & !busy                      i_mode i_col i_row i_in_*
//  result    o_out_valid (one cycle)            o_out_red/green/blue o_outside
//  config    psel & penable & pwrite & pready   paddr pwdata (prdata on read)
//
//  One word accepted every cycle; busy is never raised.
//  A render word gives its result from the blend output register; a texel
//  write gives none and lands in the store at the same stage that renders
//  read it, so words act in order. The texture banks are one read port each.
//  Synchronous reset clears the pipeline valids and loads register defaults.
//  The receiver cannot stall, so no stage ever holds.
// ----------------------------------------------------------------------------
module affine_warp_texel_sampler_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic [afw_pkg::COL_W-1:0]     i_col,
    input  logic [afw_pkg::ROW_W-1:0]     i_row,
    input  logic [afw_pkg::CH_W-1:0]      i_in_red,
    input  logic [afw_pkg::CH_W-1:0]      i_in_green,
    input  logic [afw_pkg::CH_W-1:0]      i_in_blue,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [afw_pkg::ADDR_W-1:0]    paddr,
    input  logic [afw_pkg::APB_DW-1:0]    pwdata,
    output logic [afw_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output logic                          o_out_valid,
    output logic [afw_pkg::CH_W-1:0]      o_out_red,
    output logic [afw_pkg::CH_W-1:0]      o_out_green,
    output logic [afw_pkg::CH_W-1:0]      o_out_blue,
    output logic                          o_outside
);

    localparam int CFG_W = afw_pkg::CFG_W;
    localparam int DW    = afw_pkg::APB_DW;

    afw_pkg::t_cfg                       r_cfg;
    afw_pkg::t_smp                       w_smp;
    afw_pkg::t_tex                       w_tex;
    logic [afw_pkg::REG_IDX_W-1:0]       w_idx;
    logic                                w_wr;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign w_idx  = paddr[afw_pkg::ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_mode    <= afw_pkg::SCALE_BILINEAR;
            r_cfg.empty_outside <= 1'b0;
            r_cfg.m_xx          <= CFG_W'(1 << afw_pkg::FRAC_BITS);
            r_cfg.m_xy          <= '0;
            r_cfg.m_tx          <= '0;
            r_cfg.m_yx          <= '0;
            r_cfg.m_yy          <= CFG_W'(1 << afw_pkg::FRAC_BITS);
            r_cfg.m_ty          <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                afw_pkg::REG_SCALE_MODE:
                    r_cfg.scale_mode <= pwdata[afw_pkg::MODE_W-1:0];
                afw_pkg::REG_EMPTY_OUTSIDE: r_cfg.empty_outside <= pwdata[0];
                afw_pkg::REG_M_XX:          r_cfg.m_xx <= pwdata[CFG_W-1:0];
                afw_pkg::REG_M_XY:          r_cfg.m_xy <= pwdata[CFG_W-1:0];
                afw_pkg::REG_M_TX:          r_cfg.m_tx <= pwdata[CFG_W-1:0];
                afw_pkg::REG_M_YX:          r_cfg.m_yx <= pwdata[CFG_W-1:0];
                afw_pkg::REG_M_YY:          r_cfg.m_yy <= pwdata[CFG_W-1:0];
                afw_pkg::REG_M_TY:          r_cfg.m_ty <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            afw_pkg::REG_SCALE_MODE:    prdata = DW'(r_cfg.scale_mode);
            afw_pkg::REG_EMPTY_OUTSIDE: prdata = DW'(r_cfg.empty_outside);
            afw_pkg::REG_M_XX:          prdata = DW'($signed(r_cfg.m_xx));
            afw_pkg::REG_M_XY:          prdata = DW'($signed(r_cfg.m_xy));
            afw_pkg::REG_M_TX:          prdata = DW'($signed(r_cfg.m_tx));
            afw_pkg::REG_M_YX:          prdata = DW'($signed(r_cfg.m_yx));
            afw_pkg::REG_M_YY:          prdata = DW'($signed(r_cfg.m_yy));
            afw_pkg::REG_M_TY:          prdata = DW'($signed(r_cfg.m_ty));
        endcase
    end

    afw_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_go    (start & ~busy),
        .i_mode  (i_mode),
        .i_col   (i_col),
        .i_row   (i_row),
        .i_wdata ({i_in_red, i_in_green, i_in_blue}),
        .o_smp   (w_smp)
    );

    afw_tex_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_smp   (w_smp),
        .o_tex   (w_tex)
    );

    afw_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tex     (w_tex),
        .o_valid   (o_out_valid),
        .o_red     (o_out_red),
        .o_green   (o_out_green),
        .o_blue    (o_out_blue),
        .o_outside (o_outside)
    );

endmodule
